// ----- src/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the step detector.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/amsd_pkg.sv -----
// ============================================================================
// amsd_pkg
// Types, constants and codes shared by the step detector modules.
// ============================================================================
`default_nettype none

package amsd_pkg;

   // Fixed widths of the ports.
   localparam int ACCEL_W       = 16;
   localparam int STEP_TOTAL_W  = 32;
   localparam int MAGNITUDE_W   = 16;
   localparam int THRESHOLD_W   = 16;
   localparam int HOLDOFF_W     = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   // Defaults for the top level parameters.
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   // Register reset values.
   localparam logic [THRESHOLD_W-1:0] RISE_THRESHOLD_RESET = 16'd1000;
   localparam logic [HOLDOFF_W-1:0]   HOLDOFF_SAMPLES_RESET = 8'd20;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RISE_THRESHOLD  = 1'b0,
      CSR_HOLDOFF_SAMPLES = 1'b1
   } csr_index_type;

   // Configuration handed to the back end.
   typedef struct packed {
      logic [THRESHOLD_W-1:0] rise_threshold;
      logic [HOLDOFF_W-1:0]   holdoff_samples;
   } csr_type;

   // Front end sequencer states.
   typedef enum logic [2:0] {
      F_IDLE,
      F_SQ_X,
      F_SQ_Y,
      F_SQ_Z,
      F_ACC,
      F_PUSH
   } front_state_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      B_IDLE,
      B_ROOT,
      B_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/amsd_front.sv -----
// ============================================================================
// amsd_front
// Takes one sample, forms the sum of the squared axis values with one shared
// multiplier and pushes the sum into the queue.
// ============================================================================
`default_nettype none

module amsd_front #(
   parameter int SAMPLE_WIDTH = amsd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [amsd_pkg::ACCEL_W-1:0] req_accel_x,
   input  wire logic [amsd_pkg::ACCEL_W-1:0] req_accel_y,
   input  wire logic [amsd_pkg::ACCEL_W-1:0] req_accel_z,
   output logic                             q_push,
   output logic [2*SAMPLE_WIDTH-1:0]        q_data,
   input  wire logic                        q_full
);

   localparam int SW = SAMPLE_WIDTH;

   amsd_pkg::front_state_type state_ff, state_in;

   logic [SW-1:0]   abs_x_ff, abs_y_ff, abs_z_ff;
   logic [SW-1:0]   abs_x_in, abs_y_in, abs_z_in;
   logic [SW-1:0]   mul_op;
   logic [2*SW-1:0] prod_ff;
   logic [2*SW-1:0] acc_ff;
   logic            accept;

   // Absolute values of the low SAMPLE_WIDTH bits of each axis, read as signed.
   always_comb begin
      abs_x_in = req_accel_x[SW-1] ? (~req_accel_x[SW-1:0] + 1'b1) : req_accel_x[SW-1:0];
      abs_y_in = req_accel_y[SW-1] ? (~req_accel_y[SW-1:0] + 1'b1) : req_accel_y[SW-1:0];
      abs_z_in = req_accel_z[SW-1] ? (~req_accel_z[SW-1:0] + 1'b1) : req_accel_z[SW-1:0];
   end

   assign req_full = (state_ff != amsd_pkg::F_IDLE);
   assign accept   = req_push && !req_full;
   assign q_data   = acc_ff;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amsd_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, multiplier operand and queue push.
   always_comb begin
      state_in = state_ff;
      mul_op   = abs_x_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         amsd_pkg::F_IDLE: begin
            if (accept) begin
               state_in = amsd_pkg::F_SQ_X;
            end
         end
         amsd_pkg::F_SQ_X: begin
            mul_op   = abs_x_ff;
            state_in = amsd_pkg::F_SQ_Y;
         end
         amsd_pkg::F_SQ_Y: begin
            mul_op   = abs_y_ff;
            state_in = amsd_pkg::F_SQ_Z;
         end
         amsd_pkg::F_SQ_Z: begin
            mul_op   = abs_z_ff;
            state_in = amsd_pkg::F_ACC;
         end
         amsd_pkg::F_ACC: begin
            state_in = amsd_pkg::F_PUSH;
         end
         amsd_pkg::F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = amsd_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = amsd_pkg::F_IDLE;
         end
      endcase
   end

   // Sample capture, squaring and accumulation.
   always_ff @(posedge clock) begin
      if (accept) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         abs_z_ff <= abs_z_in;
      end
      prod_ff <= mul_op * mul_op;
      if (state_ff == amsd_pkg::F_SQ_Y) begin
         acc_ff <= prod_ff;
      end else if (state_ff == amsd_pkg::F_SQ_Z || state_ff == amsd_pkg::F_ACC) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

endmodule

`default_nettype wire

// ----- src/amsd_queue.sv -----
// ============================================================================
// amsd_queue
// Short first-in first-out queue of squared sums between front and back end.
// ============================================================================
`default_nettype none

module amsd_queue #(
   parameter int WIDTH = 2 * amsd_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int DEPTH = amsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/amsd_back.sv -----
// ============================================================================
// amsd_back
// Takes a squared sum from the queue, extracts its square root in steps of
// two radicand bits, runs the step detection and holds the result word.
// ============================================================================
`default_nettype none

module amsd_back #(
   parameter int SAMPLE_WIDTH = amsd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire amsd_pkg::csr_type                   csr,
   input  wire logic [2*SAMPLE_WIDTH-1:0]           q_data,
   input  wire logic                                q_empty,
   output logic                                     q_pop,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [amsd_pkg::STEP_TOTAL_W-1:0]        rsp_step_total,
   output logic                                     rsp_step_seen,
   output logic [amsd_pkg::MAGNITUDE_W-1:0]         rsp_magnitude
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int REM_W = SW + 3;
   localparam int ITR_W = $clog2(SW);

   amsd_pkg::back_state_type state_ff, state_in;

   logic [2*SW-1:0]                   rad_ff;
   logic [REM_W-1:0]                  rem_ff, rem_sh, trial;
   logic [SW-1:0]                     root_ff;
   logic [ITR_W-1:0]                  iter_ff;
   logic                              load, step, finish, fits;

   logic                              res_valid_ff;
   logic [amsd_pkg::STEP_TOTAL_W-1:0] res_total_ff;
   logic                              res_seen_ff;
   logic [amsd_pkg::MAGNITUDE_W-1:0]  res_mag_ff;

   logic [amsd_pkg::MAGNITUDE_W-1:0]  last_mag_ff;
   logic                              hold_act_ff;
   logic [amsd_pkg::HOLDOFF_W-1:0]    hold_cnt_ff;
   logic [amsd_pkg::STEP_TOTAL_W-1:0] steps_ff;

   logic [amsd_pkg::MAGNITUDE_W-1:0]  mag;
   logic [amsd_pkg::MAGNITUDE_W:0]    limit;
   logic                              seen, act_now;
   logic                              hold_act_in;
   logic [amsd_pkg::HOLDOFF_W-1:0]    hold_cnt_in;
   logic [amsd_pkg::STEP_TOTAL_W-1:0] steps_in;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amsd_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and strobes.
   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      step     = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         amsd_pkg::B_IDLE: begin
            if (!q_empty) begin
               load     = 1'b1;
               state_in = amsd_pkg::B_ROOT;
            end
         end
         amsd_pkg::B_ROOT: begin
            step = 1'b1;
            if (iter_ff == '0) begin
               state_in = amsd_pkg::B_DONE;
            end
         end
         amsd_pkg::B_DONE: begin
            if (!res_valid_ff || rsp_pop) begin
               finish   = 1'b1;
               state_in = amsd_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = amsd_pkg::B_IDLE;
         end
      endcase
   end

   assign q_pop = load;

   // One restoring square root step: bring down two bits and try to subtract.
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[2*SW-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (load) begin
         rad_ff  <= q_data;
         rem_ff  <= '0;
         root_ff <= '0;
         iter_ff <= ITR_W'(SW - 1);
      end else if (step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[SW-2:0], fits};
         iter_ff <= iter_ff - 1'b1;
      end
   end

   // Step detection against the previous magnitude and the holdoff.
   always_comb begin
      mag     = amsd_pkg::MAGNITUDE_W'(root_ff);
      limit   = {1'b0, last_mag_ff} + {1'b0, csr.rise_threshold};
      seen    = !hold_act_ff && ({1'b0, mag} > limit);
      act_now = hold_act_ff || seen;
      steps_in    = steps_ff + {{(amsd_pkg::STEP_TOTAL_W-1){1'b0}}, seen};
      hold_act_in = act_now;
      hold_cnt_in = hold_cnt_ff;
      if (act_now) begin
         if (hold_cnt_ff < csr.holdoff_samples) begin
            hold_cnt_in = hold_cnt_ff + 1'b1;
         end else begin
            hold_cnt_in = '0;
            hold_act_in = 1'b0;
         end
      end
   end

   // Detector state, updated once per sample as its result is written.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_mag_ff <= '0;
         hold_act_ff <= 1'b0;
         hold_cnt_ff <= '0;
         steps_ff    <= '0;
      end else if (finish) begin
         last_mag_ff <= mag;
         hold_act_ff <= hold_act_in;
         hold_cnt_ff <= hold_cnt_in;
         steps_ff    <= steps_in;
      end
   end

   // Result register towards the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (finish) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         res_total_ff <= steps_in;
         res_seen_ff  <= seen;
         res_mag_ff   <= mag;
      end
   end

   assign rsp_empty      = !res_valid_ff;
   assign rsp_step_total = res_total_ff;
   assign rsp_step_seen  = res_seen_ff;
   assign rsp_magnitude  = res_mag_ff;

endmodule

`default_nettype wire

// ----- src/accel_magnitude_step_detector_top.sv -----
// ============================================================================
// accel_magnitude_step_detector_top
// Pedometer step detector on the magnitude of three-axis accelerometer words.
// ============================================================================
// Usage:
// The request side is a queue input: a sample word is taken at a clock edge
// with req_push high and req_full low. The response side is a queue output:
// while rsp_empty is low the oldest result word is on the rsp_ ports, and it
// is consumed at an edge with rsp_pop high. Every sample gives one result.
// The front end holds req_full high after taking a sample while its single
// multiplier squares the three axes and the sum is pushed into a queue of
// QUEUE_DEPTH entries (two by default). The back end loads a word, performs
// one square root step per cycle for each root bit, then finishes it, and
// takes the next word from the queue only after that.
// A stalled receiver keeps the result register full; the back end then holds
// its finished word, the queue fills and req_full stays high until rsp_pop.
// The csr_ port writes a register at any edge with csr_we high and should be
// used only while no sample is in flight.
// Reset clears the step count, holdoff and previous magnitude, restores the
// default threshold and holdoff length, and empties both sides.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module accel_magnitude_step_detector_top #(
   parameter int SAMPLE_WIDTH = amsd_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH  = amsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [amsd_pkg::ACCEL_W-1:0]         req_accel_x,
   input  wire logic [amsd_pkg::ACCEL_W-1:0]         req_accel_y,
   input  wire logic [amsd_pkg::ACCEL_W-1:0]         req_accel_z,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [amsd_pkg::STEP_TOTAL_W-1:0]         rsp_step_total,
   output logic                                      rsp_step_seen,
   output logic [amsd_pkg::MAGNITUDE_W-1:0]          rsp_magnitude,
   input  wire logic                                 csr_we,
   input  wire logic [amsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [amsd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   amsd_pkg::csr_type csr_ff;

   logic                    f_push;
   logic [2*SAMPLE_WIDTH-1:0] f_data;
   logic                    q_full;
   logic                    q_pop;
   logic [2*SAMPLE_WIDTH-1:0] q_data;
   logic                    q_empty;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.rise_threshold  <= amsd_pkg::RISE_THRESHOLD_RESET;
         csr_ff.holdoff_samples <= amsd_pkg::HOLDOFF_SAMPLES_RESET;
      end else if (csr_we) begin
         unique case (amsd_pkg::csr_index_type'(csr_index))
            amsd_pkg::CSR_RISE_THRESHOLD: begin
               csr_ff.rise_threshold <= csr_wdata[amsd_pkg::THRESHOLD_W-1:0];
            end
            amsd_pkg::CSR_HOLDOFF_SAMPLES: begin
               csr_ff.holdoff_samples <= csr_wdata[amsd_pkg::HOLDOFF_W-1:0];
            end
            default: begin
               csr_ff <= csr_ff;
            end
         endcase
      end
   end

   // Front end: sample capture and sum of squares.
   amsd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .q_push      (f_push),
      .q_data      (f_data),
      .q_full      (q_full)
   );

   // Queue between the two halves.
   amsd_queue #(
      .WIDTH (2 * SAMPLE_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // Back end: square root, detection and result register.
   amsd_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr_ff),
      .q_data         (q_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_step_total (rsp_step_total),
      .rsp_step_seen  (rsp_step_seen),
      .rsp_magnitude  (rsp_magnitude)
   );

   // Assertions.
   `AMSD_ASSERT_IMPLIES(a_push_has_room, clock, reset, f_push, !q_full)
   `AMSD_ASSERT_IMPLIES(a_pop_has_word, clock, reset, q_pop, !q_empty)
   `AMSD_ASSERT_IMPLIES(a_step_needs_rise, clock, reset, !rsp_empty && rsp_step_seen, rsp_magnitude != '0)

endmodule

`default_nettype wire
